[design/mouse_packet_position_tracker_top_defines.svh]
// Assertion macros used by the top-level RTL.
`ifndef MOUSE_PACKET_POSITION_TRACKER_TOP_DEFINES_SVH
`define MOUSE_PACKET_POSITION_TRACKER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define MPPT_ASSERT_ALWAYS(label, clock, rstn, prop, msg) \
	label: assert property (@(posedge clock) disable iff (!rstn) (prop)) else $error(msg);
`define MPPT_ASSERT_NEXT(label, clock, rstn, ante, cons, msg) \
	label: assert property (@(posedge clock) disable iff (!rstn) (ante) |=> (cons)) \
		else $error(msg);
`else
`define MPPT_ASSERT_ALWAYS(label, clock, rstn, prop, msg)
`define MPPT_ASSERT_NEXT(label, clock, rstn, ante, cons, msg)
`endif

`endif

[design/mppt_pkg.sv]
package mppt_pkg;

	localparam int BYTE_W     = 8;
	localparam int SIZE_W     = 16;
	localparam int CUR_W      = 16;
	localparam int DELTA_W    = 10;
	localparam int CFG_IDX_W  = 2;
	localparam int USER_W     = 2;

	localparam int START_BIT  = 3;
	localparam int X_SIGN_BIT = 4;
	localparam int Y_SIGN_BIT = 5;

	localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 2'd1;

	localparam logic [SIZE_W-1:0] WIDTH_RESET  = 16'd1024;
	localparam logic [SIZE_W-1:0] HEIGHT_RESET = 16'd768;

	typedef logic signed [DELTA_W-1:0] delta_t;
	typedef logic [SIZE_W-1:0] size_t;

endpackage

[design/mppt_clamp.sv]
module mppt_clamp #(
	parameter int POSITION_BITS = 16
) (
	input  logic [POSITION_BITS-1:0] pos,
	input  mppt_pkg::delta_t         delta,
	input  mppt_pkg::size_t          size,
	output logic [POSITION_BITS-1:0] pos_next
);

	localparam int LW = (POSITION_BITS > mppt_pkg::SIZE_W) ? POSITION_BITS : mppt_pkg::SIZE_W;
	localparam int SW = LW + 2;

	logic [LW-1:0]        pmax;
	logic [LW-1:0]        pos_ext;
	mppt_pkg::size_t      size_m1;
	logic [LW-1:0]        lim_full;
	logic [LW-1:0]        lim;
	logic signed [SW-1:0] sum;
	logic [LW-1:0]        result;

	assign pmax     = LW'({POSITION_BITS{1'b1}});
	assign pos_ext  = LW'(pos);
	assign size_m1  = (size == '0) ? '0 : size - mppt_pkg::SIZE_W'(1);
	assign lim_full = LW'(size_m1);
	assign lim      = (lim_full > pmax) ? pmax : lim_full;
	assign sum      = $signed({2'b00, pos_ext}) + SW'(delta);

	always_comb begin
		priority if (sum[SW-1]) begin
			result = '0;
		end else if (sum[SW-2:0] > {1'b0, lim}) begin
			result = lim;
		end else begin
			result = sum[LW-1:0];
		end
	end

	assign pos_next = result[POSITION_BITS-1:0];

endmodule

[design/mouse_packet_position_tracker_top.sv]
// PS/2 mouse packet decoder with cursor tracking. Each request carries one controller byte in
// tdata and {gui_active, from_mouse} in tuser. Bytes not from the mouse are ignored; outside
// GUI mode the byte is dropped and packet framing restarts. A packet starts on a byte with
// bit 3 set; its third byte updates the cursor by the 9-bit X and Y deltas (Y negated, so Y
// grows downward), clamps each axis to the screen size and emits one position request. One
// byte is taken every cycle: a byte passes an input register, then decode and clamp logic
// into the output register. The input stalls only while a byte that completes a packet
// waits behind a position that the output has not yet handed off.
// Screen size writes take effect at once and are meant for idle periods.
`include "mouse_packet_position_tracker_top_defines.svh"

module mouse_packet_position_tracker_top #(
	parameter int POSITION_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
	input  logic [1:0]  s_axis_tuser,   // [0] from_mouse, [1] gui_active
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,   // [15:0] cursor_x, [31:16] cursor_y
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	localparam int CW = mppt_pkg::CUR_W;
	localparam int DW = mppt_pkg::DELTA_W;

	typedef enum logic [1:0] {
		PH_HDR,
		PH_X,
		PH_Y,
		PH_BAD
	} phase_t;

	phase_t                  phase_q;
	logic [7:0]              first_q;
	logic [7:0]              second_q;
	logic [POSITION_BITS-1:0] pos_x_q;
	logic [POSITION_BITS-1:0] pos_y_q;
	mppt_pkg::size_t         width_q;
	mppt_pkg::size_t         height_q;

	logic                    valid_s1;
	logic [7:0]              byte_s1;
	logic                    mouse_s1;
	logic                    gui_s1;

	logic                    out_valid_q;
	logic [CW-1:0]           out_x_q;
	logic [CW-1:0]           out_y_q;

	logic                    live;
	logic                    produces;
	logic                    advance;
	mppt_pkg::delta_t        dx;
	mppt_pkg::delta_t        dy;
	logic [POSITION_BITS-1:0] x_next;
	logic [POSITION_BITS-1:0] y_next;

	assign live     = valid_s1 && mouse_s1 && gui_s1;
	assign produces = live && (phase_q == PH_Y);
	assign advance  = valid_s1 && (!produces || !out_valid_q || m_axis_tready);

	assign s_axis_tready = !valid_s1 || advance;
	assign cfg_ready     = 1'b1;

	assign dx = DW'($signed({first_q[mppt_pkg::X_SIGN_BIT], second_q}));
	assign dy = -DW'($signed({first_q[mppt_pkg::Y_SIGN_BIT], byte_s1}));

	mppt_clamp #(.POSITION_BITS(POSITION_BITS)) u_clamp_x (
		.pos      (pos_x_q),
		.delta    (dx),
		.size     (width_q),
		.pos_next (x_next)
	);

	mppt_clamp #(.POSITION_BITS(POSITION_BITS)) u_clamp_y (
		.pos      (pos_y_q),
		.delta    (dy),
		.size     (height_q),
		.pos_next (y_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= mppt_pkg::WIDTH_RESET;
			height_q <= mppt_pkg::HEIGHT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == mppt_pkg::REG_SCREEN_WIDTH) begin
				width_q <= cfg_data;
			end
			if (cfg_index == mppt_pkg::REG_SCREEN_HEIGHT) begin
				height_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1  <= s_axis_tdata;
			mouse_s1 <= s_axis_tuser[0];
			gui_s1   <= s_axis_tuser[1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_HDR;
			first_q     <= '0;
			second_q    <= '0;
			pos_x_q     <= '0;
			pos_y_q     <= '0;
			out_valid_q <= 1'b0;
			out_x_q     <= '0;
			out_y_q     <= '0;
		end else begin
			if (m_axis_tready && !(advance && produces)) begin
				out_valid_q <= 1'b0;
			end
			if (advance && mouse_s1) begin
				if (!gui_s1) begin
					phase_q <= PH_HDR;
				end else begin
					unique case (phase_q)
						PH_HDR: begin
							if (byte_s1[mppt_pkg::START_BIT]) begin
								first_q <= byte_s1;
								phase_q <= PH_X;
							end
						end
						PH_X: begin
							second_q <= byte_s1;
							phase_q  <= PH_Y;
						end
						PH_Y: begin
							phase_q     <= PH_HDR;
							pos_x_q     <= x_next;
							pos_y_q     <= y_next;
							out_valid_q <= 1'b1;
							out_x_q     <= CW'(x_next);
							out_y_q     <= CW'(y_next);
						end
						default: begin
							phase_q  <= PH_HDR;
							first_q  <= '0;
							second_q <= '0;
						end
					endcase
				end
			end
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {out_y_q, out_x_q};

	`MPPT_ASSERT_ALWAYS(a_phase_legal, clk, arst_n, phase_q != PH_BAD,
		"packet phase reached an unused code")
	`MPPT_ASSERT_NEXT(a_result_issued, clk, arst_n, advance && produces,
		out_valid_q && phase_q == PH_HDR, "completed packet did not issue a result")
	`MPPT_ASSERT_NEXT(a_stage_held, clk, arst_n, valid_s1 && !advance,
		valid_s1 && $stable(byte_s1), "stalled input stage lost its byte")

endmodule

[dv/tb_mouse_packet_position_tracker_top.sv]
module tb_mouse_packet_position_tracker_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DRAIN_CYCLES = 8;
	localparam int STALL_LIMIT  = 2000;
	localparam int IDLE_PCT     = 32;

	typedef enum logic [1:0] {
		WAIT_HEAD,
		WAIT_X,
		WAIT_Y,
		PHASE_BAD
	} phase_t;

	typedef struct packed {
		logic [mppt_pkg::CUR_W-1:0] y;
		logic [mppt_pkg::CUR_W-1:0] x;
	} cursor_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = '0;
	logic [1:0]  s_axis_tuser = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [31:0] m_axis_tdata;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = '0;
	logic [15:0] cfg_data = '0;

	bit no_idle = 1'b0;
	int mismatches = 0;
	int stall_cycles = 0;

	mppt_pkg::size_t            width_now = mppt_pkg::WIDTH_RESET;
	mppt_pkg::size_t            height_now = mppt_pkg::HEIGHT_RESET;
	phase_t                     phase = WAIT_HEAD;
	logic [7:0]                 head_byte = '0;
	logic [7:0]                 x_byte = '0;
	logic [mppt_pkg::CUR_W-1:0] pos_x = '0;
	logic [mppt_pkg::CUR_W-1:0] pos_y = '0;
	cursor_t                    cursor_expect[$];
	cursor_t                    cursor_want;

	mouse_packet_position_tracker_top u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic logic [mppt_pkg::CUR_W-1:0] clamp_to_screen(input int v,
		input mppt_pkg::size_t size);
		int lim;
		lim = (size == 0) ? 0 : int'(size) - 1;
		if (v < 0)
			return '0;
		if (v > lim)
			return lim[mppt_pkg::CUR_W-1:0];
		return v[mppt_pkg::CUR_W-1:0];
	endfunction

	task automatic track_byte(input logic [7:0] data, input logic mouse, input logic gui);
		int dx;
		int dy;
		if (!mouse)
			return;
		if (!gui) begin
			phase = WAIT_HEAD;
			return;
		end
		case (phase)
			WAIT_HEAD: begin
				if (data[mppt_pkg::START_BIT]) begin
					head_byte = data;
					phase = WAIT_X;
				end
			end
			WAIT_X: begin
				x_byte = data;
				phase = WAIT_Y;
			end
			WAIT_Y: begin
				phase = WAIT_HEAD;
				dx = int'(x_byte);
				if (head_byte[mppt_pkg::X_SIGN_BIT])
					dx -= 256;
				dy = int'(data);
				if (head_byte[mppt_pkg::Y_SIGN_BIT])
					dy -= 256;
				dy = -dy;
				pos_x = clamp_to_screen(int'(pos_x) + dx, width_now);
				pos_y = clamp_to_screen(int'(pos_y) + dy, height_now);
				cursor_expect.push_back('{y: pos_y, x: pos_x});
			end
			default: begin
				phase = WAIT_HEAD;
				head_byte = '0;
				x_byte = '0;
			end
		endcase
	endtask

	task automatic send_byte(input logic [7:0] data, input logic mouse, input logic gui);
		while (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= data;
		s_axis_tuser  <= {gui, mouse};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		track_byte(data, mouse, gui);
	endtask

	task automatic send_packet(input logic [7:0] b0, input logic [7:0] b1, input logic [7:0] b2);
		send_byte(b0, 1'b1, 1'b1);
		send_byte(b1, 1'b1, 1'b1);
		send_byte(b2, 1'b1, 1'b1);
	endtask

	// Drop the stream and wait until every position has come back and the pipe is empty.
	task automatic drain;
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (cursor_expect.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_screen(input mppt_pkg::size_t w, input mppt_pkg::size_t h);
		cfg_valid <= 1'b1;
		cfg_index <= mppt_pkg::REG_SCREEN_WIDTH;
		cfg_data  <= w;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		width_now = w;
		cfg_index <= mppt_pkg::REG_SCREEN_HEIGHT;
		cfg_data  <= h;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		height_now = h;
		cfg_valid <= 1'b0;
	endtask

	function automatic mppt_pkg::size_t pick_size();
		case ($urandom_range(0, 4))
			0: return mppt_pkg::size_t'(1);
			1: return mppt_pkg::size_t'($urandom_range(1, 400));
			2: return mppt_pkg::size_t'($urandom_range(1, 65535));
			3: return mppt_pkg::size_t'(16'hFFFF);
			default: return mppt_pkg::size_t'(0);
		endcase
	endfunction

	task automatic test_directed;
		send_byte(8'hFF, 1'b0, 1'b1);
		send_packet(8'h08, 8'h7F, 8'h00);
		send_packet(8'h38, 8'h80, 8'h80);
		send_byte(8'hF7, 1'b1, 1'b1);
		send_byte(8'h08, 1'b1, 1'b1);
		send_byte(8'h10, 1'b1, 1'b1);
		send_byte(8'h2C, 1'b1, 1'b0);
		send_packet(8'hFF, 8'hFF, 8'hFF);
		send_byte(8'h08, 1'b1, 1'b1);
		send_byte(8'h55, 1'b0, 1'b1);
		send_byte(8'h01, 1'b1, 1'b1);
		send_byte(8'h01, 1'b1, 1'b1);
		send_byte(8'h0C, 1'b1, 1'b1);
		send_byte(8'hAA, 1'b0, 1'b0);
		send_byte(8'h02, 1'b1, 1'b1);
		send_byte(8'h03, 1'b1, 1'b1);
		send_packet(8'h08, 8'hFF, 8'h00);
		drain();
	endtask

	task automatic test_minimum_screen;
		set_screen(16'd1, 16'd0);
		send_packet(8'h08, 8'h7F, 8'h80);
		send_packet(8'h38, 8'h80, 8'h7F);
		drain();
		set_screen(16'd0, 16'd1);
		send_packet(8'h28, 8'h40, 8'h00);
		drain();
	endtask

	// Push both axes to the top of the largest screen with no idling on either side.
	task automatic test_maximum_screen;
		set_screen(16'hFFFF, 16'hFFFF);
		no_idle = 1'b1;
		repeat (260)
			send_packet(8'h28, 8'hFF, 8'h00);
		no_idle = 1'b0;
		repeat (4)
			send_packet(8'h18, 8'h00, 8'h7F);
		drain();
	endtask

	task automatic test_random;
		int sent;
		repeat (4) begin
			set_screen(pick_size(), pick_size());
			sent = 0;
			while (sent < 275) begin
				if ($urandom_range(0, 99) < 80) begin
					send_packet(8'($urandom_range(0, 255)) | 8'h08,
						8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
					sent += 3;
				end else begin
					send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) != 0,
						$urandom_range(0, 7) != 0);
					sent += 1;
				end
			end
			drain();
		end
	endtask

	always @(posedge clk)
		m_axis_tready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (cursor_expect.size() == 0) begin
				$error("unexpected cursor request: cursor_x %0d cursor_y %0d",
					m_axis_tdata[15:0], m_axis_tdata[31:16]);
				mismatches++;
			end else begin
				cursor_want = cursor_expect.pop_front();
				if (m_axis_tdata[15:0] !== cursor_want.x) begin
					$error("cursor_x: expected %0d, got %0d", cursor_want.x, m_axis_tdata[15:0]);
					mismatches++;
				end
				if (m_axis_tdata[31:16] !== cursor_want.y) begin
					$error("cursor_y: expected %0d, got %0d", cursor_want.y, m_axis_tdata[31:16]);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
			(cfg_valid && cfg_ready)) begin
			stall_cycles = 0;
		end else begin
			stall_cycles++;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("Mismatches found");
				$finish;
			end
		end
	end

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_minimum_screen();
		test_maximum_screen();
		test_random();
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
